// ===== design/nrpn_pkg.sv =====
// nrpn_pkg: shared types and controller numbers for the nrpn sequence detector
// no dependencies; imported by the result item interface, the top level, its checker and the bench
`default_nettype none

package nrpn_pkg;

	// controller numbers that take part in a sequence
	localparam logic [6:0] CC_NRPN_MSB = 7'd99;
	localparam logic [6:0] CC_NRPN_LSB = 7'd98;
	localparam logic [6:0] CC_DATA_MSB = 7'd6;
	localparam logic [6:0] CC_DATA_LSB = 7'd38;
	localparam logic [6:0] CC_INC      = 7'd96;
	localparam logic [6:0] CC_DEC      = 7'd97;

	// result kind codes
	typedef enum logic [1:0] {
		KIND_FWD   = 2'd0,
		KIND_INC   = 2'd1,
		KIND_DEC   = 2'd2,
		KIND_ENTRY = 2'd3
	} kind_t;

	// position within a sequence
	typedef enum logic [3:0] {
		ST_IDLE      = 4'b0001,
		ST_ONE_PARAM = 4'b0010,
		ST_TWO_PARAM = 4'b0100,
		ST_ENTRY_MSB = 4'b1000
	} step_t;

endpackage

`default_nettype wire

// ===== design/nrpn_if.sv =====
// nrpn_msg_if and nrpn_evt_if: valid/ready channels for input messages and result items
// depends on nrpn_pkg for the kind type
`default_nettype none

// decoded midi message channel
interface nrpn_msg_if;
	logic       valid;
	logic       ready;
	logic       is_control_change;
	logic [3:0] channel;
	logic [6:0] controller;
	logic [6:0] value;

	modport source (output valid, output is_control_change, output channel,
		output controller, output value, input ready);
	modport sink (input valid, input is_control_change, input channel,
		input controller, input value, output ready);
endinterface

// result item channel
interface nrpn_evt_if;
	import nrpn_pkg::*;
	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [3:0]  out_channel;
	logic [13:0] number;
	logic [13:0] data;

	modport source (output valid, output kind, output out_channel, output number,
		output data, input ready);
	modport sink (input valid, input kind, input out_channel, input number,
		input data, output ready);
endinterface

`default_nettype wire

// ===== design/nrpn_sequence_detector.sv =====
// nrpn_sequence_detector: a result item is shown the cycle after its input
// item is taken. throughput 1 item per cycle: the sequence state and the result register
// are both updated in a single pass, and a new item is taken whenever the result register
// is empty or being read. arst_n clears the filter enable, the sequence state, the
// parameter bytes and the result valid; a result still waiting at reset is dropped.
// depends on nrpn_pkg and the channel interfaces in nrpn_if.sv
`default_nettype none

module nrpn_sequence_detector
	import nrpn_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	nrpn_msg_if.sink    msg,
	nrpn_evt_if.source  evt
);

	logic        filter_en_q;
	step_t       step_q, step_d;
	logic [3:0]  seq_channel_q, seq_channel_d;
	logic [6:0]  param_msb_q, param_msb_d;
	logic [6:0]  param_lsb_q, param_lsb_d;
	logic [6:0]  entry_msb_q, entry_msb_d;

	logic        evt_valid_q;
	kind_t       kind_q, kind_d;
	logic [3:0]  out_channel_q, out_channel_d;
	logic [13:0] number_q, number_d;
	logic [13:0] data_q, data_d;

	logic        accept;
	logic        emit;
	logic        is_param;
	logic [13:0] pnum;

	// item handshake: take a new item while the result register is empty or drained
	assign msg.ready = !evt_valid_q || evt.ready;
	assign accept    = msg.valid && msg.ready;

	assign is_param = (msg.controller == CC_NRPN_MSB) || (msg.controller == CC_NRPN_LSB);
	assign pnum     = {param_msb_q, param_lsb_q};

	// sequence step and result selection
	always_comb begin
		step_d        = step_q;
		seq_channel_d = seq_channel_q;
		param_msb_d   = param_msb_q;
		param_lsb_d   = param_lsb_q;
		entry_msb_d   = entry_msb_q;
		emit          = 1'b1;
		kind_d        = KIND_FWD;
		out_channel_d = msg.channel;
		number_d      = {7'd0, msg.controller};
		data_d        = {7'd0, msg.value};

		if (filter_en_q && msg.is_control_change) begin
			if (step_q == ST_IDLE) begin
				// first parameter byte opens a sequence
				if (is_param) begin
					seq_channel_d = msg.channel;
					if (msg.controller == CC_NRPN_MSB) begin
						param_msb_d = msg.value;
					end else begin
						param_lsb_d = msg.value;
					end
					step_d = ST_ONE_PARAM;
					emit   = 1'b0;
				end
			end else if (seq_channel_q != msg.channel) begin
				// channel change drops the sequence
				step_d = ST_IDLE;
			end else begin
				unique case (step_q)
					ST_ONE_PARAM: begin
						if (is_param) begin
							if (msg.controller == CC_NRPN_MSB) begin
								param_msb_d = msg.value;
							end else begin
								param_lsb_d = msg.value;
							end
							step_d = ST_TWO_PARAM;
							emit   = 1'b0;
						end else begin
							step_d = ST_IDLE;
						end
					end
					ST_TWO_PARAM: begin
						step_d = ST_IDLE;
						priority if (msg.controller == CC_DATA_MSB) begin
							entry_msb_d = msg.value;
							step_d      = ST_ENTRY_MSB;
							emit        = 1'b0;
						end else if (msg.controller == CC_INC) begin
							kind_d        = KIND_INC;
							out_channel_d = seq_channel_q;
							number_d      = pnum;
						end else if (msg.controller == CC_DEC) begin
							kind_d        = KIND_DEC;
							out_channel_d = seq_channel_q;
							number_d      = pnum;
						end else begin
							kind_d = KIND_FWD;
						end
					end
					ST_ENTRY_MSB: begin
						step_d = ST_IDLE;
						if (msg.controller == CC_DATA_LSB) begin
							kind_d        = KIND_ENTRY;
							out_channel_d = seq_channel_q;
							number_d      = pnum;
							data_d        = {entry_msb_q, msg.value};
						end
					end
					default: begin
						step_d = ST_IDLE;
					end
				endcase
			end
		end
	end

	// filter enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= 1'b0;
		end else if (cfg_we) begin
			filter_en_q <= cfg_wdata;
		end
	end

	// sequence state, advanced on each taken item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= ST_IDLE;
			seq_channel_q <= 4'd0;
			param_msb_q   <= 7'd0;
			param_lsb_q   <= 7'd0;
			entry_msb_q   <= 7'd0;
		end else if (accept) begin
			step_q        <= step_d;
			seq_channel_q <= seq_channel_d;
			param_msb_q   <= param_msb_d;
			param_lsb_q   <= param_lsb_d;
			entry_msb_q   <= entry_msb_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (accept) begin
			evt_valid_q <= emit;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind_q        <= kind_d;
			out_channel_q <= out_channel_d;
			number_q      <= number_d;
			data_q        <= data_d;
		end
	end

	assign evt.valid       = evt_valid_q;
	assign evt.kind        = kind_q;
	assign evt.out_channel = out_channel_q;
	assign evt.number      = number_q;
	assign evt.data        = data_q;

endmodule

`default_nettype wire

// ===== design/nrpn_chk.sv =====
// nrpn_chk: port-level assertions for nrpn_sequence_detector, attached by bind
// depends on nrpn_pkg and on the top level's ports
`default_nettype none

module nrpn_chk
	import nrpn_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_is_cc,
	input wire logic [6:0]  in_controller,
	input wire logic [6:0]  in_value,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  out_kind,
	input wire logic [13:0] out_number,
	input wire logic [13:0] out_data
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// input is only held off by a waiting, unread result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// a non control change item is forwarded on the next cycle unchanged
	a_non_cc_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_is_cc |=> out_valid && out_kind == KIND_FWD
			&& out_number == {7'd0, $past(in_controller)}
			&& out_data == {7'd0, $past(in_value)})
		else $error("non control change item not forwarded");

	// increment and decrement amounts come from one value byte
	a_incdec_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_INC || out_kind == KIND_DEC)
			|-> out_data[13:7] == 7'd0)
		else $error("increment or decrement amount out of range");

endmodule

bind nrpn_sequence_detector nrpn_chk u_nrpn_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (msg.valid),
	.in_ready      (msg.ready),
	.in_is_cc      (msg.is_control_change),
	.in_controller (msg.controller),
	.in_value      (msg.value),
	.out_valid     (evt.valid),
	.out_ready     (evt.ready),
	.out_kind      (evt.kind),
	.out_number    (evt.number),
	.out_data      (evt.data)
);

`default_nettype wire

// ===== bench/nrpn_event_checker.sv =====
// nrpn_event_checker: watches the message and result channels of the nrpn sequence detector,
// predicts every result item from the accepted messages and compares field by field
// depends on nrpn_pkg and the channel interfaces in nrpn_if.sv

module nrpn_event_checker
	import nrpn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	nrpn_msg_if  msg,
	nrpn_evt_if  evt,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  chan;
		logic [13:0] number;
		logic [13:0] data;
	} nrpn_result_t;

	// results predicted but not yet seen, oldest first
	nrpn_result_t expected_results[$];

	// predictor copy of the detector state
	logic       filter_on;
	step_t      seq_step;
	logic [3:0] seq_chan;
	logic [6:0] param_hi;
	logic [6:0] param_lo;
	logic [6:0] entry_hi;

	task automatic report_mismatch(input string text);
		fail_count++;
		$display("[%0t] mismatch: %s", $time, text);
	endtask

	task automatic push_result(input kind_t k, input logic [3:0] c, input logic [13:0] n,
		input logic [13:0] d);
		nrpn_result_t r;
		r.kind = k;
		r.chan = c;
		r.number = n;
		r.data = d;
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic store_param_byte(input logic [6:0] ctrl, input logic [6:0] val);
		if (ctrl == CC_NRPN_MSB)
			param_hi = val;
		else
			param_lo = val;
	endtask

	// advance the sequence state for one message and queue the result, if any, that it causes
	task automatic decode_message(input logic is_cc, input logic [3:0] ch,
		input logic [6:0] ctrl, input logic [6:0] val);
		logic        is_param;
		logic [13:0] param_num;
		logic        forward;
		is_param = (ctrl == CC_NRPN_MSB) || (ctrl == CC_NRPN_LSB);
		param_num = {param_hi, param_lo};
		forward = 1'b1;
		if (filter_on && is_cc) begin
			if (seq_step == ST_IDLE && is_param) begin
				seq_chan = ch;
				store_param_byte(ctrl, val);
				seq_step = ST_ONE_PARAM;
				forward = 1'b0;
			end else if (seq_step != ST_IDLE && seq_chan != ch) begin
				// channel change drops the sequence
				seq_step = ST_IDLE;
			end else begin
				case (seq_step)
					ST_ONE_PARAM: begin
						if (is_param) begin
							store_param_byte(ctrl, val);
							seq_step = ST_TWO_PARAM;
							forward = 1'b0;
						end else begin
							seq_step = ST_IDLE;
						end
					end
					ST_TWO_PARAM: begin
						if (ctrl == CC_DATA_MSB) begin
							entry_hi = val;
							seq_step = ST_ENTRY_MSB;
							forward = 1'b0;
						end else begin
							seq_step = ST_IDLE;
							if (ctrl == CC_INC) begin
								push_result(KIND_INC, seq_chan, param_num, {7'd0, val});
								forward = 1'b0;
							end else if (ctrl == CC_DEC) begin
								push_result(KIND_DEC, seq_chan, param_num, {7'd0, val});
								forward = 1'b0;
							end
						end
					end
					ST_ENTRY_MSB: begin
						seq_step = ST_IDLE;
						if (ctrl == CC_DATA_LSB) begin
							push_result(KIND_ENTRY, seq_chan, param_num, {entry_hi, val});
							forward = 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
		if (forward)
			push_result(KIND_FWD, ch, {7'd0, ctrl}, {7'd0, val});
	endtask

	// compare results first, then predict from the message taken at the same edge
	always @(posedge clk or negedge arst_n) begin : check_proc
		nrpn_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			filter_on = 1'b0;
			seq_step = ST_IDLE;
			seq_chan = '0;
			param_hi = '0;
			param_lo = '0;
			entry_hi = '0;
			pending <= 0;
		end else begin
			if (cfg_we)
				filter_on = cfg_wdata;
			if (evt.valid && evt.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: kind %0d ch %0d num %0d data %0d",
						evt.kind, evt.out_channel, evt.number, evt.data));
				end else begin
					want = expected_results.pop_front();
					if (evt.kind !== want.kind)
						report_mismatch($sformatf("kind got %0d, expected %0d", evt.kind, want.kind));
					if (evt.out_channel !== want.chan)
						report_mismatch($sformatf("out_channel got %0d, expected %0d",
							evt.out_channel, want.chan));
					if (evt.number !== want.number)
						report_mismatch($sformatf("number got %0d, expected %0d",
							evt.number, want.number));
					if (evt.data !== want.data)
						report_mismatch($sformatf("data got %0d, expected %0d", evt.data, want.data));
				end
			end
			if (msg.valid && msg.ready)
				decode_message(msg.is_control_change, msg.channel, msg.controller, msg.value);
			pending <= expected_results.size();
		end
	end

endmodule

// ===== bench/tb_nrpn_sequence_detector.sv =====
// tb_nrpn_sequence_detector: drives midi messages and filter settings into the nrpn
// sequence detector, with random idling on both channels; nrpn_event_checker does the checking
// depends on nrpn_pkg, nrpn_if.sv, nrpn_event_checker and the detector itself

module tb_nrpn_sequence_detector;
	timeunit 1ns;
	timeprecision 1ps;
	import nrpn_pkg::*;

	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic       is_cc;
		logic [3:0] ch;
		logic [6:0] ctrl;
		logic [6:0] val;
	} midi_msg_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fail_count;
	int   pending;
	int   items_sent;
	int   stall_left;
	int   idle_cycles;
	bit   quiet;

	nrpn_msg_if msg_bus();
	nrpn_evt_if evt_bus();

	nrpn_sequence_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.msg       (msg_bus),
		.evt       (evt_bus)
	);

	nrpn_event_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.msg        (msg_bus),
		.evt        (evt_bus),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: random stall bursts, none once quiet
	always @(posedge clk) begin
		if (stall_left > 0) begin
			evt_bus.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			evt_bus.ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			evt_bus.ready <= 1'b1;
		end
	end

	// watchdog on cycles without any item moving
	always @(posedge clk) begin
		if ((msg_bus.valid && msg_bus.ready) || (evt_bus.valid && evt_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("tb_nrpn_sequence_detector: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic midi_msg_t mk(input logic is_cc, input logic [3:0] ch,
		input logic [6:0] ctrl, input logic [6:0] val);
		midi_msg_t m;
		m.is_cc = is_cc;
		m.ch = ch;
		m.ctrl = ctrl;
		m.val = val;
		return m;
	endfunction

	// offer one item, with an optional idle burst ahead of it
	task automatic send_msg(input midi_msg_t m);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			msg_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		msg_bus.valid <= 1'b1;
		msg_bus.is_control_change <= m.is_cc;
		msg_bus.channel <= m.ch;
		msg_bus.controller <= m.ctrl;
		msg_bus.value <= m.val;
		@(posedge clk);
		while (!msg_bus.ready) @(posedge clk);
		items_sent++;
	endtask

	// hold the sender off until every predicted result has arrived
	task automatic wait_for_results();
		msg_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_filter(input logic en);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [6:0] pick_param_ctrl();
		return $urandom_range(0, 1) ? CC_NRPN_MSB : CC_NRPN_LSB;
	endfunction

	// well-formed sequence with random content, now and then broken
	task automatic send_random_sequence();
		midi_msg_t  seq[$];
		logic [3:0] ch;
		int         brk;
		ch = $urandom_range(0, 15);
		seq.insert(seq.size(), mk(1'b1, ch, pick_param_ctrl(), 7'($urandom)));
		seq.insert(seq.size(), mk(1'b1, ch, pick_param_ctrl(), 7'($urandom)));
		case ($urandom_range(0, 2))
			0: seq.insert(seq.size(), mk(1'b1, ch, CC_INC, 7'($urandom)));
			1: seq.insert(seq.size(), mk(1'b1, ch, CC_DEC, 7'($urandom)));
			default: begin
				seq.insert(seq.size(), mk(1'b1, ch, CC_DATA_MSB, 7'($urandom)));
				seq.insert(seq.size(), mk(1'b1, ch, CC_DATA_LSB, 7'($urandom)));
			end
		endcase
		if ($urandom_range(0, 4) == 0) begin
			brk = $urandom_range(0, seq.size() - 1);
			case ($urandom_range(0, 2))
				0: seq[brk].ch = seq[brk].ch + 4'($urandom_range(1, 15));
				1: seq[brk].ctrl = 7'($urandom);
				default: seq.insert(brk, mk(1'b0, 4'($urandom), 7'($urandom), 7'($urandom)));
			endcase
		end
		foreach (seq[i])
			send_msg(seq[i]);
	endtask

	// loose message, biased toward the controllers that matter
	task automatic send_noise();
		logic [6:0] ctrl;
		case ($urandom_range(0, 11))
			0: ctrl = CC_NRPN_MSB;
			1: ctrl = CC_NRPN_LSB;
			2: ctrl = CC_DATA_MSB;
			3: ctrl = CC_DATA_LSB;
			4: ctrl = CC_INC;
			5: ctrl = CC_DEC;
			default: ctrl = 7'($urandom);
		endcase
		send_msg(mk(1'($urandom), 4'($urandom), ctrl, 7'($urandom)));
	endtask

	task automatic run_random(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) < 7)
				send_random_sequence();
			else
				send_noise();
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		quiet = 1'b0;
		msg_bus.valid = 1'b0;
		msg_bus.is_control_change = 1'b0;
		msg_bus.channel = '0;
		msg_bus.controller = '0;
		msg_bus.value = '0;
		evt_bus.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// filter off: everything is forwarded
		write_filter(1'b0);
		send_msg(mk(1'b0, 4'd15, 7'd127, 7'd127));
		send_msg(mk(1'b1, 4'd0, CC_NRPN_MSB, 7'd0));
		send_msg(mk(1'b1, 4'd7, CC_DATA_MSB, 7'd64));

		write_filter(1'b1);
		// increment and decrement with extreme parameter bytes
		send_msg(mk(1'b1, 4'd5, CC_NRPN_MSB, 7'd127));
		send_msg(mk(1'b1, 4'd5, CC_NRPN_LSB, 7'd0));
		send_msg(mk(1'b1, 4'd5, CC_INC, 7'd127));
		send_msg(mk(1'b1, 4'd5, CC_NRPN_LSB, 7'd127));
		send_msg(mk(1'b1, 4'd5, CC_NRPN_MSB, 7'd0));
		send_msg(mk(1'b1, 4'd5, CC_DEC, 7'd0));
		// full data entry, all ones
		send_msg(mk(1'b1, 4'd15, CC_NRPN_MSB, 7'd127));
		send_msg(mk(1'b1, 4'd15, CC_NRPN_LSB, 7'd127));
		send_msg(mk(1'b1, 4'd15, CC_DATA_MSB, 7'd127));
		send_msg(mk(1'b1, 4'd15, CC_DATA_LSB, 7'd127));
		// channel change mid-sequence on a parameter controller
		send_msg(mk(1'b1, 4'd1, CC_NRPN_MSB, 7'd3));
		send_msg(mk(1'b1, 4'd2, CC_NRPN_LSB, 7'd4));
		// non-cc inside a sequence leaves it running
		send_msg(mk(1'b1, 4'd0, CC_NRPN_MSB, 7'd1));
		send_msg(mk(1'b0, 4'd0, CC_NRPN_LSB, 7'd9));
		send_msg(mk(1'b1, 4'd0, CC_NRPN_LSB, 7'd2));
		send_msg(mk(1'b1, 4'd0, CC_DATA_MSB, 7'd0));
		send_msg(mk(1'b1, 4'd0, CC_DATA_LSB, 7'd0));
		// broken after one, two and three sequence messages
		send_msg(mk(1'b1, 4'd3, CC_NRPN_MSB, 7'd5));
		send_msg(mk(1'b1, 4'd3, 7'd7, 7'd1));
		send_msg(mk(1'b1, 4'd3, CC_NRPN_LSB, 7'd0));
		send_msg(mk(1'b1, 4'd3, CC_NRPN_MSB, 7'd0));
		send_msg(mk(1'b1, 4'd3, 7'd0, 7'd0));
		send_msg(mk(1'b1, 4'd4, CC_NRPN_MSB, 7'd1));
		send_msg(mk(1'b1, 4'd4, CC_NRPN_LSB, 7'd1));
		send_msg(mk(1'b1, 4'd4, CC_DATA_MSB, 7'd1));
		send_msg(mk(1'b1, 4'd4, 7'd127, 7'd127));

		// random traffic across filter settings, quiet at the end
		run_random(200);
		wait_for_results();
		run_random(200);
		write_filter(1'b0);
		run_random(150);
		write_filter(1'b1);
		quiet = 1'b1;
		run_random(250);
		wait_for_results();

		if (fail_count == 0 && pending == 0)
			$display("tb_nrpn_sequence_detector: PASS");
		else
			$display("tb_nrpn_sequence_detector: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
design/nrpn_pkg.sv
design/nrpn_if.sv
design/nrpn_sequence_detector.sv
design/nrpn_chk.sv
bench/nrpn_event_checker.sv
bench/tb_nrpn_sequence_detector.sv
